>>> src/bgb_pkg.sv
// ----------------------------------------------------------------------------
// bgb_pkg
// shared types and constants of the glyph blitter
// ----------------------------------------------------------------------------
package bgb_pkg;

  localparam int GLYPHS      = 256;
  localparam int CELL_MAX    = 8;
  localparam int STORE_DEPTH = GLYPHS * CELL_MAX;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int GLYPH_W     = (GLYPHS > 1) ? $clog2(GLYPHS) : 1;
  localparam int ROW_W       = $clog2(CELL_MAX + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 72;
  localparam int OUT_DATA_W  = 32;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_DRAW = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_W   = 3'd0,
    REG_CELL_H   = 3'd1,
    REG_FIRST    = 3'd2,
    REG_COUNT    = 3'd3,
    REG_SURF_W   = 3'd4,
    REG_SURF_H   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0]  cell_width;
    logic [3:0]  cell_height;
    logic [15:0] first_code;
    logic [8:0]  glyph_count;
    logic [11:0] surface_width;
    logic [11:0] surface_height;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        char_code;
    logic signed [12:0] origin_x;
    logic signed [12:0] origin_y;
    logic [7:0]         ink;
  } draw_req_t;

endpackage

>>> src/bitmap_glyph_blit.sv
// ----------------------------------------------------------------------------
// bitmap_glyph_blit
// character generator: glyph row store and clipped pixel-write stream
//
//   channel   dir  handshake                   content
//   s_axis    in   s_axis_tvalid/tready        load row or draw character
//   m_axis    out  m_axis_tvalid/tready        pixel write, tlast on final
//   cfg       in   cfg_valid/cfg_ready         register index and data
//
// load beats are taken back to back; a draw beat holds s_axis_tready low until
// the walker is done: one store read per cell row, one pixel a cycle while
// m_axis does not stall, and no store read at all for a dropped code.
// the store is not cleared by reset: a row reads back only once loaded.
// output register plus a one-pixel hold stage; the walker freezes while
// both are full and m_axis stalls.
// ----------------------------------------------------------------------------
module bitmap_glyph_blit
  import bgb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // row_index[10:0], row_bits[18:11], char_code[34:19], origin_x[47:35],
  // origin_y[60:48], ink[68:61], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // func
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pixel_x[11:0], pixel_y[23:12], pixel_color[31:24]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t          cfg;
  draw_req_t     req;
  logic          s_fire, is_draw, start, walk_idle;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic [10:0]   row_index;

  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign is_draw   = s_axis_tuser == FUNC_DRAW;
  assign start     = s_fire && is_draw;
  assign row_index = s_axis_tdata[10:0];
  assign ram_we    = s_fire && !is_draw && (32'(row_index) < STORE_DEPTH);

  assign req.char_code = s_axis_tdata[34:19];
  assign req.origin_x  = s_axis_tdata[47:35];
  assign req.origin_y  = s_axis_tdata[60:48];
  assign req.ink       = s_axis_tdata[68:61];

  assign s_axis_tready = walk_idle;

  bgb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bgb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(row_index)),
    .wdata_i (s_axis_tdata[18:11]),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bgb_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .start_i     (start),
    .req_i       (req),
    .idle_o      (walk_idle),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tlast_o   (m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("glyph store written and read in the same cycle");

  a_draw_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !s_axis_tready)
    else $error("input accepted right after a draw beat");

  a_pixel_clipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[11:0] < cfg.surface_width)
                      && (m_axis_tdata[23:12] < cfg.surface_height))
    else $error("pixel beat outside the surface");
`endif

endmodule

>>> src/bgb_ram.sv
// ----------------------------------------------------------------------------
// bgb_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module bgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/bgb_cfg.sv
// ----------------------------------------------------------------------------
// bgb_cfg
// configuration register file
// ----------------------------------------------------------------------------
module bgb_cfg
  import bgb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_CELL_W: cfg_d.cell_width     = cfg_data_i[3:0];
        REG_CELL_H: cfg_d.cell_height    = cfg_data_i[3:0];
        REG_FIRST:  cfg_d.first_code     = cfg_data_i;
        REG_COUNT:  cfg_d.glyph_count    = cfg_data_i[8:0];
        REG_SURF_W: cfg_d.surface_width  = cfg_data_i[11:0];
        REG_SURF_H: cfg_d.surface_height = cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cell_width     <= 4'd8;
      cfg_q.cell_height    <= 4'd8;
      cfg_q.first_code     <= 16'd32;
      cfg_q.glyph_count    <= 9'd96;
      cfg_q.surface_width  <= 12'd320;
      cfg_q.surface_height <= 12'd240;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

endmodule

>>> src/bgb_walk.sv
// ----------------------------------------------------------------------------
// bgb_walk
// glyph walker: reads cell rows from the store, clips, emits pixel beats
// ----------------------------------------------------------------------------
module bgb_walk
  import bgb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  start_i,
  input  draw_req_t             req_i,
  output logic                  idle_o,
  output logic                  ram_re_o,
  output logic [AW-1:0]         ram_raddr_o,
  input  logic [7:0]            ram_rdata_i,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [OUT_DATA_W-1:0] m_tdata_o,
  output logic                  m_tlast_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } state_e;

  state_e            state_q, state_d;
  draw_req_t         req_q, req_d;
  logic [AW-1:0]     base_q, base_d;
  logic [7:0]        colmask_q, colmask_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ROW_W-1:0]  nrows_q, nrows_d;
  logic [13:0]       iss_y_q, iss_y_d;
  logic [13:0]       rd_y_q, rd_y_d;
  logic              rd_pend_q, rd_pend_d;
  logic [7:0]        mask_q, mask_d;
  logic [11:0]       cur_y_q, cur_y_d;
  logic              hold_vld_q, hold_vld_d;
  logic [11:0]       hold_x_q, hold_x_d;
  logic [11:0]       hold_y_q, hold_y_d;
  logic              out_vld_q, out_vld_d;
  logic [11:0]       out_x_q, out_x_d;
  logic [11:0]       out_y_q, out_y_d;
  logic [7:0]        out_c_q, out_c_d;
  logic              out_last_q, out_last_d;

  logic [3:0]        cw_sat, ch_sat;
  logic [16:0]       gi;
  logic              gi_ok;
  logic [13:0]       dx;
  logic [2:0]        lead;
  logic [2:0]        col;
  logic [12:0]       px_sum;
  logic              out_free, step, emit, single, consume, issue, finish, row_ok;

  assign cw_sat = (cfg_i.cell_width  > 4'(CELL_MAX)) ? 4'(CELL_MAX) : cfg_i.cell_width;
  assign ch_sat = (cfg_i.cell_height > 4'(CELL_MAX)) ? 4'(CELL_MAX) : cfg_i.cell_height;

  assign gi    = {1'b0, req_q.char_code} - {1'b0, cfg_i.first_code};
  assign gi_ok = !gi[16] && (32'(gi[15:0]) < 32'(cfg_i.glyph_count))
                 && (32'(gi[15:0]) < GLYPHS);

  // leftmost pending pixel of the current row
  always_comb begin
    lead = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (mask_q[i]) begin
        lead = 3'(i);
      end
    end
  end

  assign col    = 3'd7 - lead;
  assign px_sum = req_q.origin_x + 13'(col);
  assign row_ok = !rd_y_q[13] && (rd_y_q[12:0] < {1'b0, cfg_i.surface_height});

  assign out_free = !out_vld_q || m_tready_i;
  assign step     = !hold_vld_q || out_free;
  assign emit     = mask_q != 8'd0;
  assign single   = (mask_q & (mask_q - 8'd1)) == 8'd0;
  assign consume  = rd_pend_q && single;
  assign issue    = (row_q < nrows_q) && (!rd_pend_q || consume);
  assign finish   = !emit && !rd_pend_q && (row_q == nrows_q);

  assign ram_raddr_o = base_q + AW'(row_q);

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    base_d     = base_q;
    colmask_d  = colmask_q;
    row_d      = row_q;
    nrows_d    = nrows_q;
    iss_y_d    = iss_y_q;
    rd_y_d     = rd_y_q;
    rd_pend_d  = rd_pend_q;
    mask_d     = mask_q;
    cur_y_d    = cur_y_q;
    hold_vld_d = hold_vld_q;
    hold_x_d   = hold_x_q;
    hold_y_d   = hold_y_q;
    out_vld_d  = out_vld_q;
    out_x_d    = out_x_q;
    out_y_d    = out_y_q;
    out_c_d    = out_c_q;
    out_last_d = out_last_q;
    ram_re_o   = 1'b0;
    dx         = 14'd0;

    if (out_vld_q && m_tready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          req_d   = req_i;
          state_d = ST_SETUP;
        end
      end

      ST_SETUP: begin
        base_d = AW'(AW'(gi[GLYPH_W-1:0]) * AW'(ch_sat));
        for (int c = 0; c < 8; c++) begin
          dx = {req_q.origin_x[12], req_q.origin_x} + 14'(c);
          colmask_d[7-c] = (4'(c) < cw_sat) && !dx[13]
                           && (dx[12:0] < {1'b0, cfg_i.surface_width});
        end
        nrows_d    = gi_ok ? ROW_W'(ch_sat) : '0;
        row_d      = '0;
        iss_y_d    = {req_q.origin_y[12], req_q.origin_y};
        rd_pend_d  = 1'b0;
        mask_d     = 8'd0;
        hold_vld_d = 1'b0;
        state_d    = ST_RUN;
      end

      ST_RUN: begin
        if (step) begin
          if (emit) begin
            if (hold_vld_q) begin
              out_vld_d  = 1'b1;
              out_x_d    = hold_x_q;
              out_y_d    = hold_y_q;
              out_c_d    = req_q.ink;
              out_last_d = 1'b0;
            end
            hold_vld_d = 1'b1;
            hold_x_d   = px_sum[11:0];
            hold_y_d   = cur_y_q;
          end
          if (consume) begin
            mask_d    = ram_rdata_i & colmask_q & {8{row_ok}};
            cur_y_d   = rd_y_q[11:0];
            rd_pend_d = 1'b0;
          end else begin
            mask_d = mask_q & ~(8'd1 << lead);
          end
          if (issue) begin
            ram_re_o  = 1'b1;
            rd_y_d    = iss_y_q;
            iss_y_d   = iss_y_q + 14'd1;
            row_d     = row_q + ROW_W'(1);
            rd_pend_d = 1'b1;
          end
          if (finish) begin
            if (hold_vld_q) begin
              out_vld_d  = 1'b1;
              out_x_d    = hold_x_q;
              out_y_d    = hold_y_q;
              out_c_d    = req_q.ink;
              out_last_d = 1'b1;
            end
            hold_vld_d = 1'b0;
            state_d    = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_pend_q  <= 1'b0;
      mask_q     <= 8'd0;
      row_q      <= '0;
      nrows_q    <= '0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_pend_q  <= rd_pend_d;
      mask_q     <= mask_d;
      row_q      <= row_d;
      nrows_q    <= nrows_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    base_q     <= base_d;
    colmask_q  <= colmask_d;
    iss_y_q    <= iss_y_d;
    rd_y_q     <= rd_y_d;
    cur_y_q    <= cur_y_d;
    hold_x_q   <= hold_x_d;
    hold_y_q   <= hold_y_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_c_q    <= out_c_d;
    out_last_q <= out_last_d;
  end

  assign idle_o     = state_q == ST_IDLE;
  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = {out_c_q, out_y_q, out_x_q};
  assign m_tlast_o  = out_last_q;

endmodule
